// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCFS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FCFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FCFS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define FCFS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/fcfs_pkg.sv
// ----------------------------------------------------------------------------
// Face cull and flat shade package
// Register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package fcfs_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int SHADE_W = 16;
   localparam int PROD_W = 104;
   localparam int ROOT_W = 136;
   localparam int STAGES = 25;

   localparam logic [15:0] INTENSITY_RESET = 16'd256;

   typedef enum logic [2:0] {
      CSR_EYE_X,
      CSR_EYE_Y,
      CSR_EYE_Z,
      CSR_LAMP_X,
      CSR_LAMP_Y,
      CSR_LAMP_Z,
      CSR_LAMP_INTENSITY
   } csr_index_type;

endpackage

`default_nettype wire

// File: sv/face_cull_flat_shade_unit.sv
// ----------------------------------------------------------------------------
// Face cull and flat shade unit
// Back-face test and exact flat Lambert shade for one triangle per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Contents
//  req_*     in         req_valid/req_stall   three vertices and face number
//  rsp_*     out        rsp_valid/rsp_stall   visible flag, shade, texture slot
//  APB       in/out     psel/penable/pready   eye, lamp and intensity registers
//
// One request enters per clock while req_stall is low. The pipeline has
// sixteen square-root comparison stages after nine stages of products and
// sums. Reset clears all valid bits and the eye and lamp registers and sets
// the intensity to 256; there is no clearing pass. A stall holds only the
// stages that are full, so bubbles close up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module face_cull_flat_shade_unit #(
   parameter int TEXTURE_SLOTS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_first_x,
   input  logic signed [15:0]                  req_first_y,
   input  logic signed [15:0]                  req_first_z,
   input  logic signed [15:0]                  req_second_x,
   input  logic signed [15:0]                  req_second_y,
   input  logic signed [15:0]                  req_second_z,
   input  logic signed [15:0]                  req_third_x,
   input  logic signed [15:0]                  req_third_y,
   input  logic signed [15:0]                  req_third_z,
   input  logic        [15:0]                  req_face_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_visible,
   output logic [fcfs_pkg::SHADE_W-1:0]        rsp_shade,
   output logic [4:0]                          rsp_texture_slot,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fcfs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fcfs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fcfs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int NS = fcfs_pkg::STAGES;
   localparam int RW = fcfs_pkg::ROOT_W;
   localparam int PW = fcfs_pkg::PROD_W;
   localparam int FW = $clog2(TEXTURE_SLOTS) + 1;

   // Configuration registers.
   logic signed [15:0] eye_ff [3];
   logic signed [15:0] lamp_ff [3];
   logic [15:0] intensity_ff;
   fcfs_pkg::csr_index_type csr_idx;

   assign csr_idx = fcfs_pkg::csr_index_type'(paddr[4:2]);
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            eye_ff[i] <= '0;
            lamp_ff[i] <= '0;
         end
         intensity_ff <= fcfs_pkg::INTENSITY_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (csr_idx)
            fcfs_pkg::CSR_EYE_X: eye_ff[0] <= pwdata[15:0];
            fcfs_pkg::CSR_EYE_Y: eye_ff[1] <= pwdata[15:0];
            fcfs_pkg::CSR_EYE_Z: eye_ff[2] <= pwdata[15:0];
            fcfs_pkg::CSR_LAMP_X: lamp_ff[0] <= pwdata[15:0];
            fcfs_pkg::CSR_LAMP_Y: lamp_ff[1] <= pwdata[15:0];
            fcfs_pkg::CSR_LAMP_Z: lamp_ff[2] <= pwdata[15:0];
            fcfs_pkg::CSR_LAMP_INTENSITY: intensity_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         fcfs_pkg::CSR_EYE_X: prdata = {16'd0, eye_ff[0]};
         fcfs_pkg::CSR_EYE_Y: prdata = {16'd0, eye_ff[1]};
         fcfs_pkg::CSR_EYE_Z: prdata = {16'd0, eye_ff[2]};
         fcfs_pkg::CSR_LAMP_X: prdata = {16'd0, lamp_ff[0]};
         fcfs_pkg::CSR_LAMP_Y: prdata = {16'd0, lamp_ff[1]};
         fcfs_pkg::CSR_LAMP_Z: prdata = {16'd0, lamp_ff[2]};
         fcfs_pkg::CSR_LAMP_INTENSITY: prdata = {16'd0, intensity_ff};
         default: prdata = '0;
      endcase
   end

   // Pipeline control.
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] rdy;

   always_comb begin
      rdy[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !rdy[0];

   // Stage 0: edges and vectors from the first vertex.
   logic signed [15:0] p1 [3];
   logic signed [15:0] p2 [3];
   logic signed [15:0] p3 [3];
   logic signed [16:0] s0_e1_ff [3];
   logic signed [16:0] s0_e2_ff [3];
   logic signed [16:0] s0_te_ff [3];
   logic signed [16:0] s0_tl_ff [3];
   logic [15:0] s0_face_ff;

   always_comb begin
      p1[0] = req_first_x;
      p1[1] = req_first_y;
      p1[2] = req_first_z;
      p2[0] = req_second_x;
      p2[1] = req_second_y;
      p2[2] = req_second_z;
      p3[0] = req_third_x;
      p3[1] = req_third_y;
      p3[2] = req_third_z;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int i = 0; i < 3; i++) begin
            s0_e1_ff[i] <= 17'(p2[i]) - 17'(p1[i]);
            s0_e2_ff[i] <= 17'(p3[i]) - 17'(p1[i]);
            s0_te_ff[i] <= 17'(eye_ff[i]) - 17'(p1[i]);
            s0_tl_ff[i] <= 17'(lamp_ff[i]) - 17'(p1[i]);
         end
         s0_face_ff <= req_face_number;
      end
   end

   // Stage 1: cross product terms.
   logic signed [33:0] s1_pa_ff [3];
   logic signed [33:0] s1_pb_ff [3];
   logic signed [16:0] s1_te_ff [3];
   logic signed [16:0] s1_tl_ff [3];
   logic [15:0] s1_face_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_pa_ff[0] <= s0_e1_ff[1] * s0_e2_ff[2];
         s1_pb_ff[0] <= s0_e2_ff[1] * s0_e1_ff[2];
         s1_pa_ff[1] <= s0_e2_ff[0] * s0_e1_ff[2];
         s1_pb_ff[1] <= s0_e1_ff[0] * s0_e2_ff[2];
         s1_pa_ff[2] <= s0_e1_ff[0] * s0_e2_ff[1];
         s1_pb_ff[2] <= s0_e2_ff[0] * s0_e1_ff[1];
         s1_te_ff <= s0_te_ff;
         s1_tl_ff <= s0_tl_ff;
         s1_face_ff <= s0_face_ff;
      end
   end

   // Stage 2: normal and squared light vector components.
   logic signed [33:0] lsq_s [3];
   logic signed [34:0] s2_n_ff [3];
   logic [33:0] s2_lsq_ff [3];
   logic signed [16:0] s2_te_ff [3];
   logic signed [16:0] s2_tl_ff [3];
   logic s2_lz_ff;
   logic [15:0] s2_face_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lsq_s[i] = s1_tl_ff[i] * s1_tl_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int i = 0; i < 3; i++) begin
            s2_n_ff[i] <= 35'(s1_pa_ff[i]) - 35'(s1_pb_ff[i]);
            s2_lsq_ff[i] <= unsigned'(lsq_s[i]);
         end
         s2_lz_ff <= (s1_tl_ff[0] == '0) && (s1_tl_ff[1] == '0) && (s1_tl_ff[2] == '0);
         s2_te_ff <= s1_te_ff;
         s2_tl_ff <= s1_tl_ff;
         s2_face_ff <= s1_face_ff;
      end
   end

   // Stage 3: dot product terms and squared normal components.
   logic signed [69:0] nsq_s [3];
   logic signed [51:0] s3_pv_ff [3];
   logic signed [51:0] s3_pl_ff [3];
   logic [65:0] s3_nsq_ff [3];
   logic [33:0] s3_l_ff;
   logic s3_nz_ff;
   logic s3_lz_ff;
   logic [15:0] s3_face_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nsq_s[i] = s2_n_ff[i] * s2_n_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int i = 0; i < 3; i++) begin
            s3_pv_ff[i] <= s2_n_ff[i] * s2_te_ff[i];
            s3_pl_ff[i] <= s2_n_ff[i] * s2_tl_ff[i];
            s3_nsq_ff[i] <= nsq_s[i][65:0];
         end
         s3_l_ff <= s2_lsq_ff[0] + s2_lsq_ff[1] + s2_lsq_ff[2];
         s3_nz_ff <= (s2_n_ff[0] == '0) && (s2_n_ff[1] == '0) && (s2_n_ff[2] == '0);
         s3_lz_ff <= s2_lz_ff;
         s3_face_ff <= s2_face_ff;
      end
   end

   // Stage 4: dot products, decisions and squared norms.
   logic signed [53:0] dview;
   logic signed [53:0] dlight;
   logic [51:0] s4_d_ff;
   logic [67:0] s4_n_ff;
   logic [33:0] s4_l_ff;
   logic s4_vis_ff;
   logic s4_lit_ff;
   logic [15:0] s4_face_ff;

   always_comb begin
      dview = 54'(s3_pv_ff[0]) + 54'(s3_pv_ff[1]) + 54'(s3_pv_ff[2]);
      dlight = 54'(s3_pl_ff[0]) + 54'(s3_pl_ff[1]) + 54'(s3_pl_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_vis_ff <= !s3_nz_ff && !dview[53] && (dview != '0);
         s4_lit_ff <= !s3_nz_ff && !s3_lz_ff && !dlight[53] && (dlight != '0);
         s4_d_ff <= unsigned'(dlight[51:0]);
         s4_n_ff <= 68'(s3_nsq_ff[0]) + 68'(s3_nsq_ff[1]) + 68'(s3_nsq_ff[2]);
         s4_l_ff <= s3_l_ff;
         s4_face_ff <= s3_face_ff;
      end
   end

   // Stage 5: partial products of d squared, N times L and intensity squared.
   logic [63:0] s5_dll_ff;
   logic [51:0] s5_dhl_ff;
   logic [39:0] s5_dhh_ff;
   logic [63:0] s5_q00_ff;
   logic [63:0] s5_q10_ff;
   logic [35:0] s5_q20_ff;
   logic [33:0] s5_q01_ff;
   logic [33:0] s5_q11_ff;
   logic [5:0] s5_q21_ff;
   logic [31:0] s5_i2_ff;
   logic s5_vis_ff;
   logic s5_lit_ff;
   logic [15:0] s5_face_ff;

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_dll_ff <= s4_d_ff[31:0] * s4_d_ff[31:0];
         s5_dhl_ff <= s4_d_ff[51:32] * s4_d_ff[31:0];
         s5_dhh_ff <= s4_d_ff[51:32] * s4_d_ff[51:32];
         s5_q00_ff <= s4_n_ff[31:0] * s4_l_ff[31:0];
         s5_q10_ff <= s4_n_ff[63:32] * s4_l_ff[31:0];
         s5_q20_ff <= s4_n_ff[67:64] * s4_l_ff[31:0];
         s5_q01_ff <= s4_n_ff[31:0] * s4_l_ff[33:32];
         s5_q11_ff <= s4_n_ff[63:32] * s4_l_ff[33:32];
         s5_q21_ff <= s4_n_ff[67:64] * s4_l_ff[33:32];
         s5_i2_ff <= intensity_ff * intensity_ff;
         s5_vis_ff <= s4_vis_ff;
         s5_lit_ff <= s4_lit_ff;
         s5_face_ff <= s4_face_ff;
      end
   end

   // Stage 6: sums of the partial products.
   logic [PW-1:0] s6_d2_ff;
   logic [PW-1:0] s6_nl_ff;
   logic [31:0] s6_i2_ff;
   logic s6_vis_ff;
   logic s6_lit_ff;
   logic [15:0] s6_face_ff;

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_d2_ff <= (PW'(s5_dhh_ff) << 64) + (PW'(s5_dhl_ff) << 33) + PW'(s5_dll_ff);
         s6_nl_ff <= PW'(s5_q00_ff) + (PW'(s5_q10_ff) << 32) + (PW'(s5_q20_ff) << 64)
                   + (PW'(s5_q01_ff) << 32) + (PW'(s5_q11_ff) << 64)
                   + (PW'(s5_q21_ff) << 96);
         s6_i2_ff <= s5_i2_ff;
         s6_vis_ff <= s5_vis_ff;
         s6_lit_ff <= s5_lit_ff;
         s6_face_ff <= s5_face_ff;
      end
   end

   // Stage 7: partial products of the right-hand side.
   logic [57:0] s7_r_ff [4];
   logic [PW-1:0] s7_nl_ff;
   logic s7_vis_ff;
   logic s7_lit_ff;
   logic [15:0] s7_face_ff;

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         for (int k = 0; k < 4; k++) begin
            s7_r_ff[k] <= s6_i2_ff * s6_d2_ff[26*k +: 26];
         end
         s7_nl_ff <= s6_nl_ff;
         s7_vis_ff <= s6_vis_ff;
         s7_lit_ff <= s6_lit_ff;
         s7_face_ff <= s6_face_ff;
      end
   end

   // Stage 8 loads the root stages; each following stage settles one shade bit
   // and one bit of the face number remainder.
   logic [RW-1:0] rsum;
   logic [RW-1:0] rem_ff [17];
   logic [RW-1:0] y_ff [17];
   logic [RW-1:0] nl_ff [17];
   logic [15:0] s_ff [17];
   logic [FW-1:0] frem_ff [17];
   logic [15:0] face_ff [17];
   logic vis_ff [17];
   logic lit_ff [17];

   assign rsum = RW'(s7_r_ff[0]) + (RW'(s7_r_ff[1]) << 26) + (RW'(s7_r_ff[2]) << 52)
               + (RW'(s7_r_ff[3]) << 78);

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         rem_ff[0] <= rsum;
         y_ff[0] <= '0;
         nl_ff[0] <= RW'(s7_nl_ff);
         s_ff[0] <= '0;
         frem_ff[0] <= '0;
         face_ff[0] <= s7_face_ff;
         vis_ff[0] <= s7_vis_ff;
         lit_ff[0] <= s7_lit_ff;
      end
   end

   for (genvar j = 0; j < 16; j++) begin : g_root
      localparam int B = 15 - j;
      logic [RW-1:0] trial;
      logic take;
      logic [FW-1:0] ft;

      always_comb begin
         trial = (y_ff[j] << (B + 1)) + (nl_ff[j] << (2 * B));
         take = trial <= rem_ff[j];
         ft = FW'({frem_ff[j], face_ff[j][B]});
      end

      always_ff @(posedge clock) begin
         if (rdy[9+j]) begin
            rem_ff[j+1] <= take ? rem_ff[j] - trial : rem_ff[j];
            y_ff[j+1] <= take ? y_ff[j] + (nl_ff[j] << B) : y_ff[j];
            s_ff[j+1] <= take ? (s_ff[j] | (16'd1 << B)) : s_ff[j];
            frem_ff[j+1] <= (ft >= FW'(TEXTURE_SLOTS)) ? ft - FW'(TEXTURE_SLOTS) : ft;
            nl_ff[j+1] <= nl_ff[j];
            face_ff[j+1] <= face_ff[j];
            vis_ff[j+1] <= vis_ff[j];
            lit_ff[j+1] <= lit_ff[j];
         end
      end
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_visible = vis_ff[16];
   assign rsp_shade = lit_ff[16] ? s_ff[16] : '0;
   assign rsp_texture_slot = 5'(frem_ff[16]);

   `FCFS_ASSERT_IMPLY(a_shade_le_intensity, clock, reset, rsp_valid, rsp_shade <= intensity_ff)
   `FCFS_ASSERT_IMPLY(a_slot_range, clock, reset, rsp_valid, 9'(rsp_texture_slot) < 9'(TEXTURE_SLOTS) || TEXTURE_SLOTS > 32)
   `FCFS_ASSERT_NEXT(a_head_holds, clock, reset, vld_ff[0] && !rdy[0], vld_ff[0] && $stable(s0_face_ff))

endmodule

`default_nettype wire

// File: test/tb_face_cull_flat_shade_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Face cull and flat shade unit testbench
// Streams directed and random triangles through the unit under several eye,
// lamp and intensity settings. An exact integer predictor computes visibility,
// shade and texture slot for every accepted request, and a monitor compares
// each result against the oldest prediction while both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_face_cull_flat_shade_unit;

   localparam int AW = fcfs_pkg::CSR_ADDR_W;
   localparam int DW = fcfs_pkg::CSR_DATA_W;

   typedef struct packed {
      logic [8:0][15:0] vtx;
      logic [15:0]      face;
   } triangle_type;

   typedef struct packed {
      logic        visible;
      logic [15:0] shade;
      logic [4:0]  slot;
   } face_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic signed [15:0] req_vtx [9] = '{default: '0};
   logic [15:0] req_face_number = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_visible;
   logic [fcfs_pkg::SHADE_W-1:0] rsp_shade;
   logic [4:0]  rsp_texture_slot;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [AW-1:0] paddr = '0;
   logic [DW-1:0] pwdata = '0;
   logic [DW-1:0] prdata;
   logic        pready;

   logic signed [15:0] eye_pos [3];
   logic signed [15:0] lamp_pos [3];
   logic [15:0]        lamp_gain;

   triangle_type    triangle_queue [$];
   face_result_type shade_queue [$];
   int  error_count = 0;
   int  result_count = 0;
   int  visible_count = 0;
   int  lit_count = 0;
   int  send_gap = 0;
   int  hold_count = 0;
   bit  send_burst = 1'b0;
   bit  recv_burst = 1'b0;
   bit  long_hold_trig = 1'b0;
   bit  long_hold_seen = 1'b0;

   face_cull_flat_shade_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_x(req_vtx[0]), .req_first_y(req_vtx[1]), .req_first_z(req_vtx[2]),
      .req_second_x(req_vtx[3]), .req_second_y(req_vtx[4]), .req_second_z(req_vtx[5]),
      .req_third_x(req_vtx[6]), .req_third_y(req_vtx[7]), .req_third_z(req_vtx[8]),
      .req_face_number(req_face_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_visible(rsp_visible), .rsp_shade(rsp_shade),
      .rsp_texture_slot(rsp_texture_slot),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic face_result_type shade_face(input triangle_type t);
      longint p1 [3];
      longint e1 [3];
      longint e2 [3];
      longint nv [3];
      longint te [3];
      longint tl [3];
      longint dview;
      longint dlight;
      logic [199:0] nsq;
      logic [199:0] lsq;
      logic [199:0] nl;
      logic [199:0] rhs;
      logic [199:0] mg;
      logic [199:0] cand;
      logic [15:0]  s;
      face_result_type r;
      dview = 0;
      dlight = 0;
      nsq = '0;
      lsq = '0;
      for (int i = 0; i < 3; i++) begin
         p1[i] = longint'($signed(t.vtx[i]));
         e1[i] = longint'($signed(t.vtx[3 + i])) - p1[i];
         e2[i] = longint'($signed(t.vtx[6 + i])) - p1[i];
         te[i] = longint'(eye_pos[i]) - p1[i];
         tl[i] = longint'(lamp_pos[i]) - p1[i];
      end
      nv[0] = e1[1] * e2[2] - e2[1] * e1[2];
      nv[1] = e2[0] * e1[2] - e1[0] * e2[2];
      nv[2] = e1[0] * e2[1] - e2[0] * e1[1];
      for (int i = 0; i < 3; i++) begin
         dview += nv[i] * te[i];
         dlight += nv[i] * tl[i];
         mg = 200'(nv[i] < 0 ? -nv[i] : nv[i]);
         nsq += mg * mg;
         mg = 200'(tl[i] < 0 ? -tl[i] : tl[i]);
         lsq += mg * mg;
      end
      r.visible = (nsq != 0) && (dview > 0);
      s = '0;
      if (nsq != 0 && lsq != 0 && dlight > 0) begin
         nl = nsq * lsq;
         mg = 200'(dlight);
         rhs = 200'(lamp_gain) * 200'(lamp_gain) * mg * mg;
         for (int b = 15; b >= 0; b--) begin
            cand = 200'(s | (16'd1 << b));
            if (cand * cand * nl <= rhs) s = cand[15:0];
         end
      end
      r.shade = s;
      r.slot = 5'(t.face % 32);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH result %0d %s: got %0d, expected %0d", result_count, what, got, want);
      error_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (triangle_queue.size() > 0) begin
            triangle_type t;
            t = triangle_queue.pop_front();
            for (int i = 0; i < 9; i++) req_vtx[i] <= t.vtx[i];
            req_face_number <= t.face;
            req_valid <= 1'b1;
            send_gap <= send_burst ? 0 : $urandom_range(0, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Prediction on every accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         triangle_type t;
         for (int i = 0; i < 9; i++) t.vtx[i] = req_vtx[i];
         t.face = req_face_number;
         shade_queue.insert(shade_queue.size(), shade_face(t));
      end
   end

   // Result receiver stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_trig != long_hold_seen) begin
         long_hold_seen <= long_hold_trig;
         hold_count <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         hold_count <= recv_burst ? 0 : $urandom_range(0, 14);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shade_queue.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            face_result_type e;
            e = shade_queue.pop_front();
            if (rsp_visible !== e.visible) report_mismatch("visible", rsp_visible, e.visible);
            if (rsp_shade !== e.shade) report_mismatch("shade", rsp_shade, e.shade);
            if (rsp_texture_slot !== e.slot)
               report_mismatch("texture_slot", rsp_texture_slot, e.slot);
            visible_count += e.visible;
            lit_count += (e.shade != 0);
         end
         result_count++;
      end
   end

   task automatic write_csr(input fcfs_pkg::csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= AW'(idx * 4);
      pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         fcfs_pkg::CSR_EYE_X: eye_pos[0] = value;
         fcfs_pkg::CSR_EYE_Y: eye_pos[1] = value;
         fcfs_pkg::CSR_EYE_Z: eye_pos[2] = value;
         fcfs_pkg::CSR_LAMP_X: lamp_pos[0] = value;
         fcfs_pkg::CSR_LAMP_Y: lamp_pos[1] = value;
         fcfs_pkg::CSR_LAMP_Z: lamp_pos[2] = value;
         fcfs_pkg::CSR_LAMP_INTENSITY: lamp_gain = value;
         default: ;
      endcase
   endtask

   task automatic set_scene(input logic [15:0] ex, ey, ez, lx, ly, lz, gain);
      write_csr(fcfs_pkg::CSR_EYE_X, ex);
      write_csr(fcfs_pkg::CSR_EYE_Y, ey);
      write_csr(fcfs_pkg::CSR_EYE_Z, ez);
      write_csr(fcfs_pkg::CSR_LAMP_X, lx);
      write_csr(fcfs_pkg::CSR_LAMP_Y, ly);
      write_csr(fcfs_pkg::CSR_LAMP_Z, lz);
      write_csr(fcfs_pkg::CSR_LAMP_INTENSITY, gain);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (triangle_queue.size() > 0 || req_valid || shade_queue.size() > 0);
      repeat (fcfs_pkg::STAGES + 10) @(posedge clock);
   endtask

   task automatic add_triangle(input logic [15:0] a0, a1, a2, b0, b1, b2,
                               c0, c1, c2, input logic [15:0] face);
      triangle_type t;
      t.vtx = {c2, c1, c0, b2, b1, b0, a2, a1, a0};
      t.face = face;
      triangle_queue.insert(triangle_queue.size(), t);
   endtask

   task automatic add_random(input int count, input bit local_mesh);
      triangle_type t;
      logic signed [15:0] base [3];
      for (int k = 0; k < count; k++) begin
         for (int i = 0; i < 3; i++) base[i] = 16'($urandom);
         for (int i = 0; i < 9; i++) begin
            if (local_mesh)
               t.vtx[i] = base[i % 3] + $signed(16'($urandom_range(0, 4095)) - 16'sd2048);
            else
               t.vtx[i] = 16'($urandom);
         end
         if ($urandom_range(0, 19) == 0) t.vtx[5:3] = t.vtx[2:0];
         t.face = 16'($urandom);
         triangle_queue.insert(triangle_queue.size(), t);
      end
   endtask

   task automatic add_directed();
      add_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0, 0);
      add_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0, 16'hFFFF);
      add_triangle(0, 0, 0, 256, 256, 256, 512, 512, 512, 31);
      add_triangle(0, 0, 2560, 256, 0, 2560, 0, 256, 2560, 32);
      add_triangle(0, 0, -2560, 256, 0, -2560, 0, 256, -2560, 33);
      add_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                   16'h8000, 16'h7FFF, 16'h8000, 1);
      add_triangle(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                   16'h7FFF, 16'h8000, 16'h7FFF, 2);
      add_triangle(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                   16'h7FFF, 16'h7FFF, 16'h8000, 3);
      add_triangle(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                   16'h8000, 16'h8000, 16'h7FFF, 16'hAAAA);
      add_triangle(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000, 16'h5555);
      add_triangle(100, 200, 300, 356, 200, 300, 100, 456, 300, 16'h8000);
      add_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0, 64);
   endtask

   initial begin
      int phase_items;
      eye_pos = '{default: '0};
      lamp_pos = '{default: '0};
      lamp_gain = fcfs_pkg::INTENSITY_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values: eye and lamp at the origin.
      add_directed();
      wait_drained();

      // Eye and lamp together above the unit triangle, so both can sit on P1.
      set_scene(0, 0, 2560, 0, 0, 2560, 256);
      add_directed();
      wait_drained();

      // Largest intensity.
      set_scene(0, 0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
      add_directed();
      add_random(100, 1'b1);
      wait_drained();

      // Other extremes, zero intensity.
      set_scene(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
      add_directed();
      add_random(60, 1'b0);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         set_scene(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom),
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 1024)));
         send_burst = (p % 3 == 0);
         recv_burst = (p % 3 == 1);
         phase_items = 220;
         add_random(phase_items * 3 / 4, 1'b1);
         add_random(phase_items / 4, 1'b0);
         if (p == 2) begin
            repeat (20) @(posedge clock);
            long_hold_trig = ~long_hold_trig;
         end
         wait_drained();
      end

      $display("Covered %0d triangles over ten eye/lamp/intensity settings.", result_count);
      $display("%0d came out visible and %0d received a nonzero shade.", visible_count,
               lit_count);
      if (error_count == 0) begin
         $display("face_cull_flat_shade_unit test passed");
      end else begin
         $display("face_cull_flat_shade_unit test failed");
      end
      $finish;
   end

   initial begin
      #(20 * 1000000);
      $display("face_cull_flat_shade_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire
